>>> hw/rtl/arabic_glyph_shaper_defines.svh
// Assertion macros shared by the shaper checker.
`ifndef ARABIC_GLYPH_SHAPER_DEFINES_SVH
`define ARABIC_GLYPH_SHAPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define AGS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shaper check failed");

// Next-cycle implication, disabled while reset is held.
`define AGS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shaper check failed");

`endif

>>> hw/rtl/ags_pkg.sv
// Shared types, code tables and helpers of the Arabic glyph shaper.
package ags_pkg;

    localparam logic [7:0] NL_BYTE     = 8'h0A;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] ARABIC_BASE = 8'hA0;
    localparam logic [7:0] LAM_CODE    = 8'hFB;
    localparam logic [7:0] ALEF_MADDA  = 8'hC2;
    localparam logic [7:0] ALEF_HAMZA  = 8'hC3;
    localparam logic [7:0] ALEF_PLAIN  = 8'hC7;
    localparam logic [7:0] LIG_MADDA   = 8'hF9;
    localparam logic [7:0] LIG_HAMZA   = 8'h99;
    localparam logic [7:0] LIG_PLAIN   = 8'h9D;
    localparam logic [7:0] HAA_CODE    = 8'hE7;
    localparam logic [7:0] YAA_HAMZA   = 8'hFF;
    localparam logic [7:0] YAA_SPLIT   = 8'hE9;
    localparam logic [7:0] YAA_FINAL   = 8'hF5;
    localparam logic [7:0] HAMZA_CODE  = 8'hC1;
    localparam logic [7:0] TAIL_CODE   = 8'h9F;
    localparam logic [7:0] SEEN_FIN    = 8'hBC;
    localparam logic [7:0] SHEEN_FIN   = 8'hBD;
    localparam logic [7:0] SAD_FIN     = 8'hBE;
    localparam logic [7:0] DAD_FIN     = 8'hEB;

    localparam int unsigned FORM_COUNT = 26;

    // joining classes
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_PREV = 2'd1;
    localparam logic [1:0] CLS_NEXT = 2'd2;
    localparam logic [1:0] CLS_BOTH = 2'd3;

    localparam logic [7:0] TO864 [128] = '{
        8'hA7,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
        8'h20,8'hAC,8'hC0,8'hA3,8'hA4,8'h20,8'hDB,8'h15,
        8'h20,8'h20,8'h20,8'h97,8'hDC,8'hA1,8'h20,8'h20,
        8'hB0,8'h93,8'h20,8'h20,8'h20,8'h20,8'h14,8'h81,
        8'h20,8'h20,8'hBB,8'h98,8'h95,8'h94,8'h20,8'hBF,
        8'hF3,8'hC1,8'hC2,8'hC3,8'hC4,8'hC7,8'hFF,8'hC7,
        8'hA9,8'hC9,8'hAA,8'hAB,8'hAD,8'hAE,8'hAF,8'hCF,
        8'hD0,8'hD1,8'hD2,8'hBC,8'hBD,8'hBE,8'hEB,8'hDE,
        8'hD7,8'hD8,8'hDF,8'hEE,8'hE0,8'hBA,8'hF8,8'hFC,
        8'h20,8'hFB,8'h20,8'hEF,8'hF2,8'hE7,8'hE8,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'hE9,8'hFD,8'h20,8'h20,
        8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'hDD,
        8'hF1,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20
    };

    // low two bits: joining class, upper six: form row
    localparam logic [7:0] JOINCODE [96] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h63,8'h07,8'h0B,8'h00,8'h0F,8'h13,8'h17,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h1B,8'h00,8'h1F,8'h23,8'h27,8'h00,
        8'h00,8'h00,8'h2D,8'h31,8'h01,8'h00,8'h03,8'h35,
        8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,
        8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h03,
        8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3B,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h4F,
        8'h01,8'h41,8'h00,8'h2B,8'h00,8'h00,8'h3F,8'h47,
        8'h00,8'h00,8'h4B,8'h01,8'h00,8'h00,8'h00,8'h00,
        8'h53,8'h00,8'h00,8'h57,8'h5B,8'h5F,8'h00,8'h67
    };

    localparam logic [7:0] FORM_INI [FORM_COUNT] = '{
        8'h00,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hE1,8'hD3,8'hD4,8'hD5,8'hD6,8'hC2,8'hC3,
        8'hC7,8'hD9,8'hDA,8'hE9,8'hE5,8'hE6,8'hE7,8'hE2,8'hE4,8'hE3,8'hEA,8'hC8,8'hC6
    };
    localparam logic [7:0] FORM_MED [FORM_COUNT] = '{
        8'h00,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hE1,8'hD3,8'hD4,8'hD5,8'hD6,8'hA2,8'hA5,
        8'hA8,8'hEC,8'hF7,8'hE9,8'hE5,8'hE6,8'hF4,8'hE2,8'hE4,8'hE3,8'hEA,8'hC8,8'hC6
    };
    localparam logic [7:0] FORM_FIN [FORM_COUNT] = '{
        8'h00,8'hAA,8'hAB,8'hAD,8'hAE,8'hAF,8'hBA,8'hBC,8'hBD,8'hBE,8'hEB,8'hA2,8'hA5,
        8'hA8,8'hC5,8'hED,8'hF5,8'hEF,8'hF2,8'hF3,8'hF8,8'hFB,8'hFC,8'hF6,8'hA9,8'hF5
    };

    // one shaped letter: one or two bytes, plus whether the lookahead is swallowed
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       eat;
    } t_shape;

    // up to three bytes headed for the output
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_burst;

    function automatic logic [7:0] ags_translate(input logic [7:0] b);
        return b[7] ? TO864[b[6:0]] : b;
    endfunction

    function automatic logic [7:0] ags_joincode(input logic [7:0] c);
        return (c < ARABIC_BASE) ? 8'h00 : JOINCODE[7'(c - ARABIC_BASE)];
    endfunction

    function automatic logic [1:0] ags_join_class(input logic [7:0] c);
        logic [7:0] jc;
        jc = ags_joincode(c);
        return jc[1:0];
    endfunction

endpackage

>>> hw/rtl/arabic_glyph_shaper.sv
// Arabic glyph shaper: Windows-1256 bytes in, shaped IBM-864 printer bytes out.
// Each request byte is translated, and the letter held back from the request before is
// shaped against its neighbors in the same cycle; the resulting zero to three bytes are
// registered into a three-entry output register. The output drains one byte per cycle
// while m_tready is high, so the block takes one request per cycle while each yields at
// most one byte and the output is not stalled, and a request that yields two or three
// bytes holds s_tready low until that output register has drained to its last byte.
// A letter leaves only when the next byte or a newline arrives.
module arabic_glyph_shaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import ags_pkg::*;

    logic [7:0] r_prev;
    logic [7:0] r_held;
    logic       r_held_valid;
    logic [7:0] n_prev;
    logic [7:0] n_held;
    logic       n_held_valid;

    logic       accept;
    logic       is_nl;
    logic [7:0] mapped;
    logic [7:0] after;
    t_shape     shape;
    t_burst     burst;

    assign accept = s_tvalid && s_tready;
    assign is_nl  = (s_tdata == NL_BYTE);
    assign mapped = ags_translate(s_tdata);
    assign after  = is_nl ? NL_BYTE : mapped;

    ags_shape u_shape (
        .i_cur    (r_held),
        .i_before (r_prev),
        .i_after  (after),
        .o_shape  (shape)
    );

    always_comb begin
        burst        = '0;
        n_prev       = r_prev;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        if (is_nl) begin
            if (r_held_valid) begin
                burst.cnt = 2'(shape.cnt + 2'd1);
                burst.b0  = shape.b0;
                burst.b1  = (shape.cnt == 2'd2) ? shape.b1 : NL_BYTE;
                burst.b2  = NL_BYTE;
            end else begin
                burst.cnt = 2'd1;
                burst.b0  = NL_BYTE;
            end
            n_prev       = 8'h00;
            n_held       = 8'h00;
            n_held_valid = 1'b0;
        end else if (!r_held_valid) begin
            n_held       = mapped;
            n_held_valid = 1'b1;
        end else begin
            burst.cnt = shape.cnt;
            burst.b0  = shape.b0;
            burst.b1  = shape.b1;
            if (shape.eat) begin
                n_prev       = mapped;
                n_held       = 8'h00;
                n_held_valid = 1'b0;
            end else begin
                n_prev = r_held;
                n_held = mapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 8'h00;
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
        end else if (accept) begin
            r_prev       <= n_prev;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    ags_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .o_free     (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/ags_shape.sv
// Contextual form selection for the held letter.
module ags_shape (
    input  logic [7:0]      i_cur,
    input  logic [7:0]      i_before,
    input  logic [7:0]      i_after,
    output ags_pkg::t_shape o_shape
);
    import ags_pkg::*;

    logic [7:0] code;
    logic [1:0] cls;
    logic [5:0] row;
    logic [1:0] cls_before;
    logic [1:0] cls_after;
    logic       pj;
    logic       nj;
    logic       row_ok;
    logic [7:0] ini;
    logic [7:0] med;
    logic [7:0] fin;
    logic [7:0] g;
    logic       is_alef;
    logic [7:0] lig;

    always_comb begin
        code       = ags_joincode(i_cur);
        cls        = code[1:0];
        row        = code[7:2];
        cls_before = ags_join_class(i_before);
        cls_after  = ags_join_class(i_after);
        pj         = (cls_before == CLS_NEXT) || (cls_before == CLS_BOTH);
        nj         = (cls_after == CLS_PREV) || (cls_after == CLS_BOTH);
        row_ok     = (row != 6'd0) && (row < 6'(FORM_COUNT));
        ini        = FORM_INI[5'(row)];
        med        = FORM_MED[5'(row)];
        fin        = FORM_FIN[5'(row)];
        is_alef    = (i_after == ALEF_MADDA) || (i_after == ALEF_HAMZA)
                  || (i_after == ALEF_PLAIN);
        if (i_after == ALEF_MADDA) begin
            lig = LIG_MADDA;
        end else if (i_after == ALEF_HAMZA) begin
            lig = LIG_HAMZA;
        end else begin
            lig = LIG_PLAIN;
        end

        g = i_cur;
        case (cls)
            CLS_PREV: if (pj) g = fin;
            CLS_NEXT: if (nj) g = ini;
            CLS_BOTH: begin
                if (pj && nj) g = med;
                else if (pj) g = fin;
                else if (nj) g = ini;
                else if (i_cur == HAA_CODE) g = fin;
            end
            default: g = i_cur;
        endcase

        o_shape = '0;
        o_shape.cnt = 2'd1;
        o_shape.b0  = i_cur;
        if (i_cur >= ARABIC_BASE && row_ok) begin
            if (i_cur == LAM_CODE && is_alef) begin
                o_shape.b0  = 8'(lig + {7'd0, pj});
                o_shape.eat = 1'b1;
            end else begin
                o_shape.b0 = g;
                if (i_cur == YAA_HAMZA && g == YAA_HAMZA) begin
                    o_shape.b0  = YAA_SPLIT;
                    o_shape.b1  = HAMZA_CODE;
                    o_shape.cnt = 2'd2;
                end else if (i_cur == YAA_HAMZA && g == YAA_FINAL) begin
                    o_shape.b1  = HAMZA_CODE;
                    o_shape.cnt = 2'd2;
                end
            end
        end

        // open-tail letters; the hamza byte never ends in one
        if (o_shape.cnt == 2'd1 && (o_shape.b0 == SEEN_FIN || o_shape.b0 == SHEEN_FIN
                || o_shape.b0 == SAD_FIN || o_shape.b0 == DAD_FIN)) begin
            o_shape.b1  = TAIL_CODE;
            o_shape.cnt = 2'd2;
            if (i_after == SPACE_BYTE) o_shape.eat = 1'b1;
        end
    end

endmodule

>>> hw/rtl/ags_outbuf.sv
// Three-byte result register that drains one byte per cycle while i_m_tready is high.
module ags_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ags_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast
);
    import ags_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;
    logic [7:0] n_b0;
    logic [7:0] n_b1;
    logic [7:0] n_b2;
    logic       pop;

    assign pop        = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_b0;
    assign o_m_tlast  = (r_cnt == 2'd1);
    // free when empty, or once the last queued byte leaves this cycle
    assign o_free     = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_tready);

    always_comb begin
        n_cnt = r_cnt;
        n_b0  = r_b0;
        n_b1  = r_b1;
        n_b2  = r_b2;
        if (i_load) begin
            n_cnt = i_burst.cnt;
            n_b0  = i_burst.b0;
            n_b1  = i_burst.b1;
            n_b2  = i_burst.b2;
        end else if (pop) begin
            n_cnt = 2'(r_cnt - 2'd1);
            n_b0  = r_b1;
            n_b1  = r_b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= n_b0;
        r_b1 <= n_b1;
        r_b2 <= n_b2;
    end

endmodule

>>> hw/rtl/ags_checker.sv
// Port-level checks of the shaper, bound to the top level.
`include "arabic_glyph_shaper_defines.svh"

module ags_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import ags_pkg::*;

    `AGS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // more bytes of one request still queued: no new request taken
    `AGS_ASSERT_IMP(a_busy_burst, i_clk, i_rst_n, m_tvalid && !m_tlast, !s_tready)

    // a newline always produces output on the next cycle
    `AGS_ASSERT_NXT(a_nl_emits, i_clk, i_rst_n, s_tvalid && s_tready && s_tdata == NL_BYTE,
        m_tvalid)

    // last byte taken with no request behind it leaves the output empty
    `AGS_ASSERT_NXT(a_drain_empty, i_clk, i_rst_n,
        m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready), !m_tvalid)

endmodule

bind arabic_glyph_shaper ags_checker u_ags_checker (.*);
